[src/rla_pkg.sv]
// shared types, codes and defaults of the lru register allocator
package rla_pkg;

    localparam int DEF_NUM_ENTRIES = 18;
    localparam int DEF_FIRST_REG   = 8;
    localparam int DEF_TAG_BITS    = 16;
    localparam int DEF_AGE_BITS    = 16;

    // widest index and tag any legal parameter set needs
    localparam int MAX_IDX_W = 5;
    localparam int MAX_TAG_W = 32;

    localparam int OP_W    = 2;
    localparam int TAG_W   = 16;
    localparam int REGNO_W = 5;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OLDEST,
        ST_EVICT,
        ST_FINISH
    } t_state;

    // update request from the sequencer to the entry file
    typedef struct packed {
        logic                 release_all;
        logic                 clear_all;
        logic                 write;
        logic                 touch;
        logic [MAX_IDX_W-1:0] idx;
        logic [MAX_TAG_W-1:0] tag;
    } t_tbl_cmd;

endpackage

[src/rla_entries.sv]
// entry file: busy marks, tags, tag valid bits and ages with one read port
module rla_entries #(
    parameter int NUM_ENTRIES = rla_pkg::DEF_NUM_ENTRIES,
    parameter int TAG_BITS    = rla_pkg::DEF_TAG_BITS,
    parameter int AGE_BITS    = rla_pkg::DEF_AGE_BITS,
    localparam int IDX_W      = $clog2(NUM_ENTRIES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rla_pkg::t_tbl_cmd     i_cmd,
    input  logic [IDX_W-1:0]      i_rd_idx,
    output logic                  o_rd_busy,
    output logic                  o_rd_valid,
    output logic [TAG_BITS-1:0]   o_rd_tag,
    output logic [AGE_BITS-1:0]   o_rd_age
);
    import rla_pkg::*;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic [NUM_ENTRIES-1:0] r_busy;
    logic [NUM_ENTRIES-1:0] r_valid;
    logic [TAG_BITS-1:0]    r_tag [NUM_ENTRIES];
    logic [AGE_BITS-1:0]    r_age [NUM_ENTRIES];

    logic [IDX_W-1:0]    wr_idx;
    logic [TAG_BITS-1:0] wr_tag;

    assign wr_idx = i_cmd.idx[IDX_W-1:0];
    assign wr_tag = i_cmd.tag[TAG_BITS-1:0];

    assign o_rd_busy  = r_busy[i_rd_idx];
    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_tag   = r_tag[i_rd_idx];
    assign o_rd_age   = r_age[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_busy  <= '0;
            r_valid <= '0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_tag[i] <= '0;
                r_age[i] <= '0;
            end
        end else begin
            if (i_cmd.release_all) begin
                r_busy <= '0;
            end
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (i_cmd.write && wr_idx == IDX_W'(i)) begin
                    r_busy[i]  <= 1'b1;
                    r_valid[i] <= 1'b1;
                    r_tag[i]   <= wr_tag;
                end
                // every allocation ages all entries, the chosen one restarts at zero
                if (i_cmd.touch) begin
                    if (wr_idx == IDX_W'(i)) begin
                        r_age[i] <= '0;
                    end else if (r_age[i] != AGE_MAX) begin
                        r_age[i] <= r_age[i] + 1'b1;
                    end
                end
            end
        end
    end

endmodule

[src/register_lru_allocator_top.sv]
// lru register allocator: sequencer, shared comparator and output register
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+------------------------------------------------
//  request  | i_valid  | o_stall  | i_operation, i_var_tag
//  result   | o_valid  | i_stall  | o_reg_index, o_reused, o_spilled, o_spilled_tag
//
// release-all, clear-all and unknown codes pass from acceptance through the finish state.
// an allocate walks the entries one per cycle through a single shared comparator:
// a free entry or a tag hit ends the walk; a full table with no match adds a second
// pass over all entries for the oldest, then an evict state writes the chosen entry.
// one request is in flight at a time; a finished result may wait in the output
// register while the next request is accepted and worked on.
// synchronous reset clears all entries at once; the block is ready the cycle after.
module register_lru_allocator_top #(
    parameter int NUM_ENTRIES = rla_pkg::DEF_NUM_ENTRIES,
    parameter int FIRST_REG   = rla_pkg::DEF_FIRST_REG,
    parameter int TAG_BITS    = rla_pkg::DEF_TAG_BITS,
    parameter int AGE_BITS    = rla_pkg::DEF_AGE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [rla_pkg::OP_W-1:0]     i_operation,
    input  logic [rla_pkg::TAG_W-1:0]    i_var_tag,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [rla_pkg::REGNO_W-1:0]  o_reg_index,
    output logic                         o_reused,
    output logic                         o_spilled,
    output logic [rla_pkg::TAG_W-1:0]    o_spilled_tag
);
    import rla_pkg::*;

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int CMP_W = (TAG_BITS > AGE_BITS) ? TAG_BITS : AGE_BITS;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_ENTRIES - 1);

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_chosen, n_chosen;
    logic [AGE_BITS-1:0]  r_best, n_best;
    logic [TAG_BITS-1:0]  r_tag, n_tag;
    logic [REGNO_W-1:0]   r_res_reg, n_res_reg;
    logic                 r_res_reused, n_res_reused;
    logic                 r_res_spilled, n_res_spilled;
    logic [TAG_W-1:0]     r_res_spill_tag, n_res_spill_tag;
    logic                 r_out_valid, n_out_valid;
    logic [REGNO_W-1:0]   r_out_reg, n_out_reg;
    logic                 r_out_reused, n_out_reused;
    logic                 r_out_spilled, n_out_spilled;
    logic [TAG_W-1:0]     r_out_spill_tag, n_out_spill_tag;

    t_tbl_cmd             cmd;
    logic [IDX_W-1:0]     rd_idx;
    logic                 rd_busy;
    logic                 rd_valid;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [AGE_BITS-1:0]  rd_age;

    logic [CMP_W-1:0]     cmp_a;
    logic [CMP_W-1:0]     cmp_b;
    logic                 cmp_eq;
    logic                 cmp_gt;

    rla_entries #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .TAG_BITS    (TAG_BITS),
        .AGE_BITS    (AGE_BITS)
    ) u_entries (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_rd_idx   (rd_idx),
        .o_rd_busy  (rd_busy),
        .o_rd_valid (rd_valid),
        .o_rd_tag   (rd_tag),
        .o_rd_age   (rd_age)
    );

    assign rd_idx = (r_state == ST_EVICT) ? r_chosen : r_idx;

    // one comparator: tag match in the first pass, age order in the oldest pass
    assign cmp_a  = (r_state == ST_OLDEST) ? CMP_W'(rd_age) : CMP_W'(rd_tag);
    assign cmp_b  = (r_state == ST_OLDEST) ? CMP_W'(r_best) : CMP_W'(r_tag);
    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_gt = (cmp_a > cmp_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx           <= n_idx;
        r_chosen        <= n_chosen;
        r_best          <= n_best;
        r_tag           <= n_tag;
        r_res_reg       <= n_res_reg;
        r_res_reused    <= n_res_reused;
        r_res_spilled   <= n_res_spilled;
        r_res_spill_tag <= n_res_spill_tag;
        r_out_reg       <= n_out_reg;
        r_out_reused    <= n_out_reused;
        r_out_spilled   <= n_out_spilled;
        r_out_spill_tag <= n_out_spill_tag;
    end

    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        n_chosen        = r_chosen;
        n_best          = r_best;
        n_tag           = r_tag;
        n_res_reg       = r_res_reg;
        n_res_reused    = r_res_reused;
        n_res_spilled   = r_res_spilled;
        n_res_spill_tag = r_res_spill_tag;
        n_out_valid     = r_out_valid;
        n_out_reg       = r_out_reg;
        n_out_reused    = r_out_reused;
        n_out_spilled   = r_out_spilled;
        n_out_spill_tag = r_out_spill_tag;
        cmd             = '0;
        o_stall         = (r_state != ST_IDLE);

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_tag           = TAG_BITS'(i_var_tag);
                    n_res_reg       = '0;
                    n_res_reused    = 1'b0;
                    n_res_spilled   = 1'b0;
                    n_res_spill_tag = '0;
                    n_idx           = '0;
                    n_state         = ST_FINISH;
                    unique case (i_operation)
                        OP_ALLOC:   n_state = ST_SCAN;
                        OP_RELEASE: cmd.release_all = 1'b1;
                        OP_CLEAR:   cmd.clear_all = 1'b1;
                        default:    ;
                    endcase
                end
            end
            ST_SCAN: begin
                // free test comes before the tag match for each entry
                if (!rd_busy) begin
                    cmd.write = 1'b1;
                    cmd.touch = 1'b1;
                    cmd.idx   = MAX_IDX_W'(r_idx);
                    cmd.tag   = MAX_TAG_W'(r_tag);
                    n_res_reg = REGNO_W'(FIRST_REG + 32'(r_idx));
                    n_state   = ST_FINISH;
                end else if (rd_valid && cmp_eq) begin
                    cmd.touch    = 1'b1;
                    cmd.idx      = MAX_IDX_W'(r_idx);
                    n_res_reg    = REGNO_W'(FIRST_REG + 32'(r_idx));
                    n_res_reused = 1'b1;
                    n_state      = ST_FINISH;
                end else if (r_idx == LAST) begin
                    n_idx    = '0;
                    n_best   = '0;
                    n_chosen = '0;
                    n_state  = ST_OLDEST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_OLDEST: begin
                // strict compare keeps the lowest index on ties
                if (cmp_gt) begin
                    n_best   = rd_age;
                    n_chosen = r_idx;
                end
                if (r_idx == LAST) begin
                    n_state = ST_EVICT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_EVICT: begin
                cmd.write       = 1'b1;
                cmd.touch       = 1'b1;
                cmd.idx         = MAX_IDX_W'(r_chosen);
                cmd.tag         = MAX_TAG_W'(r_tag);
                n_res_reg       = REGNO_W'(FIRST_REG + 32'(r_chosen));
                n_res_spilled   = 1'b1;
                n_res_spill_tag = TAG_W'(rd_tag);
                n_state         = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid     = 1'b1;
                    n_out_reg       = r_res_reg;
                    n_out_reused    = r_res_reused;
                    n_out_spilled   = r_res_spilled;
                    n_out_spill_tag = r_res_spill_tag;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_reg_index   = r_out_reg;
    assign o_reused      = r_out_reused;
    assign o_spilled     = r_out_spilled;
    assign o_spilled_tag = r_out_spill_tag;

    a_spill_not_reuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_spilled && o_reused))
        else $error("result marked both spilled and reused");

    a_spill_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_spilled) |-> (o_spilled_tag == '0))
        else $error("spill tag set without a spill");

    a_evict_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVICT) |-> rd_busy)
        else $error("eviction picked an entry that is not in use");

    a_finish_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_out_valid && i_stall) |=> (r_state == ST_FINISH))
        else $error("pending result dropped while output stalled");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_OLDEST) |-> (r_idx <= LAST))
        else $error("scan index beyond last entry");

endmodule

[tb/register_lru_allocator_top_tb.sv]
// testbench for the lru register allocator: predictor, scoreboard and handshake drivers
module register_lru_allocator_top_tb;
    import rla_pkg::*;

    localparam int TBL_SIZE = DEF_NUM_ENTRIES;
    localparam int BASE_REG = DEF_FIRST_REG;
    localparam logic [DEF_AGE_BITS-1:0] AGE_CEIL = '1;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [REGNO_W-1:0] reg_index;
        logic               reused;
        logic               spilled;
        logic [TAG_W-1:0]   spilled_tag;
    } t_grant;

    class t_alloc_scoreboard;
        bit                      busy[TBL_SIZE];
        logic [TAG_W-1:0]        held[TBL_SIZE];
        bit                      held_ok[TBL_SIZE];
        logic [DEF_AGE_BITS-1:0] age[TBL_SIZE];
        t_grant                  grants_due[$];
        int                      errors;
        int                      requests;
        int                      reuses;
        int                      spills;

        function new();
            clear_table();
            errors = 0;
            requests = 0;
            reuses = 0;
            spills = 0;
        endfunction

        function void clear_table();
            foreach (busy[i]) begin
                busy[i] = 1'b0;
                held[i] = '0;
                held_ok[i] = 1'b0;
                age[i] = '0;
            end
        endfunction

        // works out the grant that an accepted request must produce
        function void note_request(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag);
            t_grant g;
            int     pick;
            bit     hit;
            g = '0;
            pick = 0;
            hit = 1'b0;
            requests++;
            case (op)
                OP_RELEASE: begin
                    foreach (busy[i]) busy[i] = 1'b0;
                end
                OP_CLEAR: begin
                    clear_table();
                end
                OP_ALLOC: begin
                    // free test comes before the tag match, entry by entry
                    for (int i = 0; i < TBL_SIZE && !hit; i++) begin
                        if (!busy[i]) begin
                            busy[i] = 1'b1;
                            held[i] = tag;
                            held_ok[i] = 1'b1;
                            pick = i;
                            hit = 1'b1;
                        end else if (held_ok[i] && held[i] == tag) begin
                            pick = i;
                            g.reused = 1'b1;
                            hit = 1'b1;
                        end
                    end
                    if (!hit) begin
                        // evict the oldest, lowest index on ties
                        for (int i = 1; i < TBL_SIZE; i++) begin
                            if (age[i] > age[pick]) pick = i;
                        end
                        g.spilled = 1'b1;
                        g.spilled_tag = held[pick];
                        busy[pick] = 1'b1;
                        held[pick] = tag;
                        held_ok[pick] = 1'b1;
                    end
                    foreach (age[i]) begin
                        if (age[i] != AGE_CEIL) age[i] = age[i] + 1'b1;
                    end
                    age[pick] = '0;
                    g.reg_index = REGNO_W'(BASE_REG + pick);
                end
                default: begin
                    // unused code leaves the table alone
                end
            endcase
            grants_due.push_back(g);
        endfunction

        function void check_grant(input t_grant got);
            t_grant want;
            if (grants_due.size() == 0) begin
                $error("result transaction with no request outstanding");
                errors++;
                return;
            end
            want = grants_due.pop_front();
            if (got.reused) reuses++;
            if (got.spilled) spills++;
            if (got.reg_index !== want.reg_index) begin
                $error("reg_index: expected %0d, actual %0d", want.reg_index, got.reg_index);
                errors++;
            end
            if (got.reused !== want.reused) begin
                $error("reused: expected %0d, actual %0d", want.reused, got.reused);
                errors++;
            end
            if (got.spilled !== want.spilled) begin
                $error("spilled: expected %0d, actual %0d", want.spilled, got.spilled);
                errors++;
            end
            if (got.spilled_tag !== want.spilled_tag) begin
                $error("spilled_tag: expected %h, actual %h", want.spilled_tag, got.spilled_tag);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [OP_W-1:0]    i_operation = '0;
    logic [TAG_W-1:0]   i_var_tag = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [REGNO_W-1:0] o_reg_index;
    logic               o_reused;
    logic               o_spilled;
    logic [TAG_W-1:0]   o_spilled_tag;

    t_alloc_scoreboard sb;
    bit                idle_on = 1'b1;
    bit                hold_pending = 1'b0;
    int                quiet_cycles = 0;

    register_lru_allocator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_var_tag     (i_var_tag),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_reg_index   (o_reg_index),
        .o_reused      (o_reused),
        .o_spilled     (o_spilled),
        .o_spilled_tag (o_spilled_tag)
    );

    always #10 i_clk = ~i_clk;

    task automatic offer_request(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_var_tag <= tag;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(op, tag);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= idle_on && ($urandom_range(99) < 18);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_grant({o_reg_index, o_reused, o_spilled, o_spilled_tag});
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [TAG_W-1:0] tag_pool[32];
        int               pool_size;
        int               run_len;
        int               sent;
        int               r;
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tag extremes, reuse, ignored code, stale tag on a free entry
        offer_request(OP_ALLOC, 16'h0000);
        offer_request(OP_ALLOC, 16'hFFFF);
        offer_request(OP_ALLOC, 16'h0000);
        offer_request(OP_UNUSED, 16'hFFFF);
        offer_request(OP_RELEASE, 16'h0000);
        offer_request(OP_ALLOC, 16'hFFFF);
        offer_request(OP_CLEAR, 16'hFFFF);
        // fill the table, spill the oldest, then hit a resident tag
        for (int i = 0; i <= TBL_SIZE; i++) offer_request(OP_ALLOC, TAG_W'(16'h1111 * i));
        offer_request(OP_ALLOC, 16'h2222);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // each run works on a small set of live variables
            pool_size = $urandom_range(8, 30);
            for (int i = 0; i < pool_size; i++) tag_pool[i] = TAG_W'($urandom);
            run_len = $urandom_range(20, 80);
            for (int k = 0; k < run_len; k++) begin
                r = $urandom_range(99);
                if (r < 3) offer_request(OP_RELEASE, TAG_W'($urandom));
                else if (r < 4) offer_request(OP_CLEAR, TAG_W'($urandom));
                else if (r < 5) offer_request(OP_UNUSED, TAG_W'($urandom));
                else if (r < 9) offer_request(OP_ALLOC, TAG_W'($urandom));
                else offer_request(OP_ALLOC, tag_pool[$urandom_range(pool_size - 1)]);
                if (r >= 5 || r < 4) sent++;
                if (sent == 400) hold_pending = 1'b1;
                idle_on = !(sent >= 700 && sent < 850);
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.grants_due.size() > 0) @(posedge i_clk);
        repeat (2 * TBL_SIZE + 8) @(posedge i_clk);

        $display("covered %0d requests with random stalls and one long result hold-off",
                 sb.requests);
        $display("%0d grants reused a held tag, %0d evicted the oldest entry",
                 sb.reuses, sb.spills);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[register_lru_allocator_top.f]
src/rla_pkg.sv
src/rla_entries.sv
src/register_lru_allocator_top.sv
tb/register_lru_allocator_top_tb.sv
